/* src/rbq_pkg.sv */
// Package for the RGB blink queue sequencer: operation codes, register map,
// reset values, the deque status struct and the colour to LED line table.
// No dependencies.
`default_nettype none

package rbq_pkg;

  // Operation codes carried in tuser of the input channel.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_BACK  = 2'd1;
  localparam logic [1:0] OP_FRONT = 2'd2;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_ON_TICKS   = 2'd0;
  localparam logic [1:0] REG_GAP_TICKS  = 2'd1;
  localparam logic [1:0] REG_POLL_TICKS = 2'd2;

  localparam logic [15:0] ON_TICKS_RST   = 16'd150;
  localparam logic [15:0] GAP_TICKS_RST  = 16'd100;
  localparam logic [15:0] POLL_TICKS_RST = 16'd10;

  // What the deque tells the sequencer about its front entry.
  typedef struct packed {
    logic       empty;
    logic [2:0] front;
  } rbq_status_t;

  // Colour code to active-high lines: bit 0 red, bit 1 green, bit 2 blue.
  function automatic logic [2:0] colour_lines(input logic [2:0] code);
    logic [2:0] lines;
    case (code)
      3'd0:    lines = 3'b001;
      3'd1:    lines = 3'b010;
      3'd2:    lines = 3'b100;
      3'd3:    lines = 3'b011;
      3'd4:    lines = 3'b101;
      3'd5:    lines = 3'b110;
      3'd6:    lines = 3'b111;
      default: lines = 3'b000;
    endcase
    return lines;
  endfunction

endpackage

`default_nettype wire

/* src/rbq_deque.sv */
// Ring-buffer deque of colour codes with a registered front-entry read.
// Depends on rbq_pkg.
`default_nettype none

module rbq_deque #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [1:0]         op,
  input  wire logic [2:0]         colour,
  input  wire logic               pop,
  output rbq_pkg::rbq_status_t    stat,
  output logic                    accepted_nxt,
  output logic                    full_nxt,
  output logic [4:0]              count_nxt
);
  import rbq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  logic [2:0]    mem [QUEUE_DEPTH];
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_int_nxt;
  logic [2:0]    front_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] head_inc, head_dec, tail_inc;
  logic          room;
  logic [CW+4:0] count_ext;

  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign room     = (count_r != FULL_CNT);

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_int_nxt = count_r;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    accepted_nxt  = 1'b0;
    if (step) begin
      case (op)
        OP_TICK: begin
          if (pop) begin
            head_nxt      = head_inc;
            count_int_nxt = count_r - 1'b1;
          end
        end
        OP_BACK: begin
          if (room) begin
            wr_en         = 1'b1;
            wr_addr       = tail_r;
            tail_nxt      = tail_inc;
            count_int_nxt = count_r + 1'b1;
            accepted_nxt  = 1'b1;
          end
        end
        OP_FRONT: begin
          if (room) begin
            wr_en         = 1'b1;
            wr_addr       = head_dec;
            head_nxt      = head_dec;
            count_int_nxt = count_r + 1'b1;
            accepted_nxt  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign full_nxt  = (count_int_nxt == FULL_CNT);
  assign count_ext = {5'b0, count_int_nxt};
  assign count_nxt = count_ext[4:0];

  // The read port follows the next head, so front_r always holds the
  // entry at the head; a write to that same entry is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= colour;
    end
    if (wr_en && (wr_addr == head_nxt)) begin
      front_r <= colour;
    end else begin
      front_r <= mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_int_nxt;
    end
  end

  assign stat.empty = (count_r == '0);
  assign stat.front = front_r;

endmodule

`default_nettype wire

/* src/rbq_blink.sv */
// Blink sequencer: phase and countdown on ticks, popping the front colour
// and driving the lit lines. Depends on rbq_pkg.
`default_nettype none

module rbq_blink (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 tick,
  input  wire logic [15:0]          on_ticks,
  input  wire logic [15:0]          gap_ticks,
  input  wire logic [15:0]          poll_ticks,
  input  rbq_pkg::rbq_status_t      stat,
  output logic                      pop,
  output logic [2:0]                lit_nxt
);
  import rbq_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ON   = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic [2:0]  lit_r;

  always_comb begin
    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    lit_nxt       = lit_r;
    pop           = 1'b0;
    if (tick) begin
      if (countdown_r > 16'd1) begin
        countdown_nxt = countdown_r - 16'd1;
      end else if (phase_r == PH_ON) begin
        lit_nxt       = 3'b000;
        phase_nxt     = PH_GAP;
        countdown_nxt = gap_ticks;
      end else if (stat.empty) begin
        lit_nxt       = 3'b000;
        phase_nxt     = PH_IDLE;
        countdown_nxt = poll_ticks;
      end else begin
        pop           = 1'b1;
        lit_nxt       = colour_lines(stat.front);
        phase_nxt     = PH_ON;
        countdown_nxt = on_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      countdown_r <= 16'd1;
      lit_r       <= 3'b000;
    end else begin
      phase_r     <= phase_nxt;
      countdown_r <= countdown_nxt;
      lit_r       <= lit_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/rgb_blink_queue_sequencer_unit.sv */
// Top level of the RGB blink queue sequencer: register port, stream
// handshake and result register. Depends on rbq_pkg, rbq_deque, rbq_blink.
//
//  channel  direction  handshake                    payload
//  in_      slave      in_tvalid / in_tready        tuser: operation; tdata: colour
//  out_     master     out_tvalid / out_tready      tdata: result fields
//  cfg_     slave      psel / penable / pready      three 16-bit timing registers
//
// The queue and the countdown are updated at the edge that accepts an item, and
// the result is loaded into the output register at that same edge, so it is
// offered from the next cycle.
// A new item is taken while the result register is empty or being drained,
// so a stalled output holds the input back after one item.
// Reset clears the queue pointers, the phase and the output valid; the colour
// store itself is not cleared.
`default_nettype none

module rgb_blink_queue_sequencer_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [2:0] colour, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [0] accepted, [1] queue_full, [6:2] queue_count,
                                       // [7] red_n, [8] green_n, [9] blue_n, rest zero
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import rbq_pkg::*;

  logic [15:0] on_ticks_r, gap_ticks_r, poll_ticks_r;
  logic        step;
  logic        pop;
  logic        accepted_nxt, full_nxt;
  logic [4:0]  count_nxt;
  logic [2:0]  lit_nxt;
  logic        out_valid_r;
  logic [9:0]  result_r;
  logic        cfg_wr;
  rbq_status_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_ticks_r   <= ON_TICKS_RST;
      gap_ticks_r  <= GAP_TICKS_RST;
      poll_ticks_r <= POLL_TICKS_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_ON_TICKS:   on_ticks_r   <= cfg_pwdata[15:0];
        REG_GAP_TICKS:  gap_ticks_r  <= cfg_pwdata[15:0];
        REG_POLL_TICKS: poll_ticks_r <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_ON_TICKS:   cfg_prdata = {16'd0, on_ticks_r};
      REG_GAP_TICKS:  cfg_prdata = {16'd0, gap_ticks_r};
      REG_POLL_TICKS: cfg_prdata = {16'd0, poll_ticks_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  assign in_tready = ~out_valid_r | out_tready;
  assign step      = in_tvalid & in_tready;

  rbq_deque #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_deque (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .op           (in_tuser),
    .colour       (in_tdata[2:0]),
    .pop          (pop),
    .stat         (stat),
    .accepted_nxt (accepted_nxt),
    .full_nxt     (full_nxt),
    .count_nxt    (count_nxt)
  );

  rbq_blink u_blink (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (step && (in_tuser == OP_TICK)),
    .on_ticks   (on_ticks_r),
    .gap_ticks  (gap_ticks_r),
    .poll_ticks (poll_ticks_r),
    .stat       (stat),
    .pop        (pop),
    .lit_nxt    (lit_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= {~lit_nxt[2], ~lit_nxt[1], ~lit_nxt[0], count_nxt, full_nxt, accepted_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, result_r};

endmodule

`default_nettype wire
